FILE: hw/rtl/bmh_pkg.sv
// bmh_pkg: shared types and codes for the binary min-heap block.
// No dependencies; imported by binary_min_heap.
`timescale 1ns / 1ps
`default_nettype none

package bmh_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned CountBits = 9;

endpackage : bmh_pkg

`default_nettype wire

FILE: hw/rtl/bmh_ram.sv
// bmh_ram: generic single-write, single-read RAM with a registered read.
// No dependencies; holds the heap entries for binary_min_heap.
`timescale 1ns / 1ps
`default_nettype none

module bmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : bmh_ram

`default_nettype wire

FILE: hw/rtl/binary_min_heap.sv
// binary_min_heap: top level of the min-heap priority queue, with its sequencer.
// Depends on bmh_pkg (codes) and bmh_ram (entry store).
//
//  channel   handshake          payload
//  request   start_i / busy_o   op_i, value_i
//  result    done_o (strobe)    removed_value_o, status_o, count_after_o
//
// Steps: an insert reads the parent (UP_RD) and compares (UP_CMP) per level climbed,
// writing in UP_RD at the root or in UP_CMP on a stop; a remove reads root and last
// entry (RM_ROOT, RM_LAST; done if now empty), then DN_RDL, DN_RDR, DN_CMP per level,
// writing in DN_RDL at a leaf or DN_CMP on a stop. The RAM's single read port sets this.
// A full insert or an empty remove is answered without entering the sequencer.
// The result beat appears in the cycle after the request finishes and cannot be
// stalled. Reset empties the heap at once; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_min_heap #(
  parameter int unsigned CAPACITY    = 256,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CW          = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 op_i,
  input  logic signed [31:0]   value_i,
  output logic                 done_o,
  output logic signed [31:0]   removed_value_o,
  output bmh_pkg::status_e     status_o,
  output logic [CW-1:0]        count_after_o
);

  import bmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned VW = VALUE_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_RM_ROOT,
    ST_RM_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [AW-1:0]  hole_q, hole_d;
  logic [VW-1:0]  val_q, val_d;
  logic [VW-1:0]  lval_q, lval_d;
  logic           has_r_q, has_r_d;
  logic           done_q, done_d;
  logic [VW-1:0]  root_q, root_d;
  status_e        status_q, status_d;
  logic [CW-1:0]  cnt_out_q, cnt_out_d;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [VW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [VW-1:0]  ram_rdata;

  logic [63:0]    in_ext;
  logic [63:0]    root_ext;
  logic [IW-1:0]  left_idx;
  logic [IW-1:0]  right_idx;
  logic [IW-1:0]  count_ext;
  logic [AW-1:0]  parent_idx;
  logic           pick_r;
  logic [VW-1:0]  pick_val;
  logic [AW-1:0]  pick_idx;

  bmh_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ext     = 64'($unsigned(value_i));
  assign root_ext   = 64'($signed(root_q));
  assign left_idx   = {hole_q, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_ext  = IW'(count_q);
  assign parent_idx = AW'((hole_q - AW'(1)) >> 1);

  // right child wins only when strictly smaller
  assign pick_r   = has_r_q && ($signed(ram_rdata) < $signed(lval_q));
  assign pick_val = pick_r ? ram_rdata : lval_q;
  assign pick_idx = pick_r ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    hole_d    = hole_q;
    val_d     = val_q;
    lval_d    = lval_q;
    has_r_d   = has_r_q;
    done_d    = 1'b0;
    root_d    = root_q;
    status_d  = status_q;
    cnt_out_d = cnt_out_q;
    ram_we    = 1'b0;
    ram_waddr = hole_q;
    ram_wdata = val_q;
    ram_raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        // read port sits on the root so a remove has it in the following cycle
        if (start_i) begin
          if (op_i == OP_INSERT) begin
            if (count_q >= CW'(CAPACITY)) begin
              done_d    = 1'b1;
              root_d    = '0;
              status_d  = STATUS_FULL;
              cnt_out_d = count_q;
            end else begin
              hole_d  = count_q[AW-1:0];
              val_d   = in_ext[VW-1:0];
              root_d  = '0;
              count_d = count_q + CW'(1);
              state_d = ST_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              done_d    = 1'b1;
              root_d    = '0;
              status_d  = STATUS_EMPTY;
              cnt_out_d = count_q;
            end else begin
              count_d = count_q - CW'(1);
              state_d = ST_RM_ROOT;
            end
          end
        end
      end

      ST_UP_RD: begin
        if (hole_q == '0) begin
          ram_we    = 1'b1;
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = count_q;
          state_d   = ST_IDLE;
        end else begin
          ram_raddr = parent_idx;
          state_d   = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        ram_we = 1'b1;
        if ($signed(val_q) < $signed(ram_rdata)) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          hole_d    = parent_idx;
          state_d   = ST_UP_RD;
        end else begin
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = count_q;
          state_d   = ST_IDLE;
        end
      end

      ST_RM_ROOT: begin
        root_d    = ram_rdata;
        ram_raddr = count_q[AW-1:0];
        state_d   = ST_RM_LAST;
      end

      ST_RM_LAST: begin
        if (count_q == '0) begin
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = count_q;
          state_d   = ST_IDLE;
        end else begin
          val_d   = ram_rdata;
          hole_d  = '0;
          state_d = ST_DN_RDL;
        end
      end

      ST_DN_RDL: begin
        if (left_idx >= count_ext) begin
          ram_we    = 1'b1;
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = count_q;
          state_d   = ST_IDLE;
        end else begin
          ram_raddr = left_idx[AW-1:0];
          state_d   = ST_DN_RDR;
        end
      end

      ST_DN_RDR: begin
        lval_d  = ram_rdata;
        has_r_d = right_idx < count_ext;
        if (right_idx < count_ext) begin
          ram_raddr = right_idx[AW-1:0];
        end
        state_d = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        ram_we = 1'b1;
        if ($signed(pick_val) < $signed(val_q)) begin
          // smaller child moves up into the hole
          ram_wdata = pick_val;
          hole_d    = pick_idx;
          state_d   = ST_DN_RDL;
        end else begin
          done_d    = 1'b1;
          status_d  = STATUS_OK;
          cnt_out_d = count_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q    <= hole_d;
    val_q     <= val_d;
    lval_q    <= lval_d;
    has_r_q   <= has_r_d;
    root_q    <= root_d;
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign removed_value_o = $signed(root_ext[31:0]);
  assign status_o        = status_q;
  assign count_after_o   = cnt_out_q;

endmodule : binary_min_heap

`default_nettype wire

FILE: tb/tb_binary_min_heap.sv
// tb_binary_min_heap: self-checking testbench for the binary min-heap block.
// Keeps its own heap predictor and checks every result beat against it.
// Depends on bmh_pkg and binary_min_heap.
`timescale 1ns / 1ps

module tb_binary_min_heap;
  import bmh_pkg::*;

  localparam int unsigned HeapSlots  = 256;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned TailCycles = 40;

  typedef struct packed {
    logic signed [ValueBits-1:0] removed;
    status_e                     status;
    logic [CountBits-1:0]        count;
  } heap_result_t;

  logic                        clk_i   = 1'b0;
  logic                        rst_ni  = 1'b0;
  logic                        start_i = 1'b0;
  logic                        op_i    = OP_INSERT;
  logic signed [ValueBits-1:0] value_i = '0;
  logic                        busy_o;
  logic                        done_o;
  logic signed [ValueBits-1:0] removed_value_o;
  status_e                     status_o;
  logic [CountBits-1:0]        count_after_o;

  // predictor state
  logic signed [ValueBits-1:0] heap_vals [HeapSlots];
  int unsigned                 heap_len = 0;

  heap_result_t expected_q[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  binary_min_heap u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .count_after_o  (count_after_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("binary_min_heap test failed");
      $finish;
    end
  end

  // Applies one request to the predictor heap and returns the expected beat.
  function automatic heap_result_t predict_request(op_e op, logic signed [ValueBits-1:0] v);
    heap_result_t                r;
    int unsigned                 pos;
    int unsigned                 par;
    int unsigned                 lft;
    int unsigned                 pick;
    logic signed [ValueBits-1:0] tmp;
    r.removed = '0;
    r.status  = STATUS_OK;
    if (op == OP_INSERT) begin
      if (heap_len >= HeapSlots) begin
        r.status = STATUS_FULL;
      end else begin
        pos = heap_len;
        heap_vals[pos] = v;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!(heap_vals[pos] < heap_vals[par])) break;
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[par];
          heap_vals[par] = tmp;
          pos = par;
        end
        heap_len++;
      end
    end else if (heap_len == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.removed = heap_vals[0];
      heap_len--;
      heap_vals[0] = heap_vals[heap_len];
      par = 0;
      forever begin
        lft = 2 * par + 1;
        if (lft >= heap_len) break;
        pick = lft;
        // left child wins a tie
        if (lft + 1 < heap_len && heap_vals[lft + 1] < heap_vals[lft]) pick = lft + 1;
        if (!(heap_vals[pick] < heap_vals[par])) break;
        tmp = heap_vals[par];
        heap_vals[par] = heap_vals[pick];
        heap_vals[pick] = tmp;
        par = pick;
      end
    end
    r.count = heap_len[CountBits-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, heap_result_t want, heap_result_t got);
    if (mismatch_count < 10) begin
      $display("%0t %s: exp removed=%0d status=%0d count=%0d, got removed=%0d status=%0d count=%0d",
               $realtime, what, want.removed, want.status, want.count,
               got.removed, got.status, got.count);
    end
    mismatch_count++;
  endtask

  // Predict on each accepted beat, then check each result beat.
  always @(posedge clk_i) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_ni) begin
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        expected_q.push_back(predict_request(op_e'(op_i), value_i));
      end
      if (done_o === 1'b1) begin
        got.removed = removed_value_o;
        got.status  = status_o;
        got.count   = count_after_o;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.removed !== want.removed || got.status !== want.status ||
              got.count !== want.count) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Mix of wide random values, extremes and a narrow band that forces ties.
  function automatic logic signed [ValueBits-1:0] pick_value();
    logic signed [ValueBits-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $signed($urandom_range(0, 8)) - 4;
      1: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2: v = $signed({24'(0), 8'($urandom)});
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_request(op_e op, logic signed [ValueBits-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i    <= op;
    value_i <= v;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic test_directed();
    send_request(OP_REMOVE, 32'sh1234_5678);   // remove from empty heap
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'sh8000_0000);
    send_request(OP_INSERT, 32'sh7fff_ffff);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sh8000_0000);
    repeat (11) send_request(OP_REMOVE, 32'sh7fff_ffff);
  endtask

  // Fill to capacity, push past it, then empty and go two removes further.
  task automatic test_full_and_empty();
    int unsigned n;
    wait_drained();
    n = HeapSlots - heap_len + 3;
    repeat (n) send_request(OP_INSERT, pick_value());
    repeat (HeapSlots + 2) send_request(OP_REMOVE, $urandom);
  endtask

  task automatic test_random_mix(int unsigned items);
    int unsigned insert_pct;
    insert_pct = 60;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 25;
          1: insert_pct = 50;
          2: insert_pct = 70;
          default: insert_pct = 90;
        endcase
      end
      // sender holds off once until everything is back
      if (i == items / 2) wait_drained();
      if ($urandom_range(1, 100) <= insert_pct) begin
        send_request(OP_INSERT, pick_value());
      end else begin
        send_request(OP_REMOVE, $urandom);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_and_empty();
    test_random_mix(800);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("binary_min_heap test passed");
    end else begin
      $display("binary_min_heap test failed");
    end
    $finish;
  end

endmodule
